/* sv/bpss_pkg.sv */
// types and constants shared by the boiler power slot scheduler
// word layouts, register indexes, flow mode bits and scheduler state
// no dependencies
package bpss_pkg;

  // slot counts never exceed 31, so five bits cover every frame size
  localparam int SLOT_W = 5;
  localparam int DEMAND_W = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECO_MODE = 1'd1;
  localparam int CFG_DATA_W = 2;

  // flow mode bits: bit 0 stops the pump, bit 1 closes the water valve
  localparam int FLOW_PUMP_OFF_BIT = 0;
  localparam int FLOW_VALVE_SHUT_BIT = 1;

  typedef struct packed {
    logic                lever_on;
    logic                tank_empty;
    logic                boiler_low;
    logic [DEMAND_W-1:0] brew_demand;
    logic [DEMAND_W-1:0] steam_demand;
  } in_word_t;

  typedef struct packed {
    logic pump_on;
    logic water_valve_open;
    logic fill_valve_open;
    logic brew_heater_on;
    logic steam_heater_on;
    logic brewing;
  } out_word_t;

  typedef struct packed {
    logic              brew_active;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] brew_slots;
    logic [SLOT_W-1:0] steam_slots;
  } sched_state_t;

endpackage

/* sv/bpss_tick.sv */
// per-tick logic: pump and valve drive, frame demand latch, slot select
// depends on bpss_pkg
// purely combinational; the caller holds state and result registers
module bpss_tick #(
  parameter int FRAME_SLOTS = 25
) (
  input  bpss_pkg::in_word_t     in_word,
  input  bpss_pkg::sched_state_t state,
  input  logic [1:0]             flow_mode,
  input  logic                   eco_mode,
  output bpss_pkg::out_word_t    out_word,
  output bpss_pkg::sched_state_t state_next
);
  import bpss_pkg::*;

  localparam logic [SLOT_W-1:0] FRAME = SLOT_W'(FRAME_SLOTS);
  localparam logic [SLOT_W:0]   FRAME_WIDE = (SLOT_W + 1)'(FRAME_SLOTS);

  logic              brewing;
  logic              refill;
  logic              active_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] b_sat;
  logic [SLOT_W-1:0] s_sat;
  logic [SLOT_W-1:0] b_share;
  logic [SLOT_W-1:0] s_share;
  logic [SLOT_W+1:0] b_x3;
  logic [SLOT_W-1:0] brew_cur;
  logic [SLOT_W-1:0] steam_cur;
  logic [SLOT_W:0]   frame_used;
  logic              bh;
  logic              sh;

  // brew flag and refill decision
  always_comb begin
    brewing = 1'b0;
    refill = 1'b0;
    active_next = state.brew_active;
    if (!state.brew_active) begin
      if (!in_word.tank_empty) begin
        if (in_word.lever_on) begin
          brewing = 1'b1;
          active_next = 1'b1;
        end else if (in_word.boiler_low) begin
          refill = 1'b1;
        end
      end
    end else begin
      if (in_word.lever_on) begin
        brewing = 1'b1;
      end else begin
        active_next = 1'b0;
      end
    end
  end

  // frame position, wrapped if it ever lands outside the frame
  assign idx = (state.slot_index >= FRAME) ? '0 : state.slot_index;

  // saturate demands to the frame, eco drops steam, share on overflow
  always_comb begin
    b_sat = (in_word.brew_demand > DEMAND_W'(FRAME_SLOTS)) ? FRAME
                                                           : in_word.brew_demand[SLOT_W-1:0];
    s_sat = (in_word.steam_demand > DEMAND_W'(FRAME_SLOTS)) ? FRAME
                                                            : in_word.steam_demand[SLOT_W-1:0];
    if (eco_mode) begin
      s_sat = '0;
    end
    b_x3 = {2'b00, b_sat} + {1'b0, b_sat, 1'b0};
    b_share = b_sat;
    s_share = s_sat;
    if (({1'b0, b_sat} + {1'b0, s_sat}) > FRAME_WIDE) begin
      if (!brewing) begin
        b_share = b_x3[SLOT_W+1:2];
      end
      s_share = FRAME - b_share;
    end
  end

  // latched shares are refreshed only at frame start
  assign brew_cur = (idx == '0) ? b_share : state.brew_slots;
  assign steam_cur = (idx == '0) ? s_share : state.steam_slots;

  // brew slots first, then steam slots, then idle
  assign frame_used = {1'b0, brew_cur} + {1'b0, steam_cur};
  assign bh = idx < brew_cur;
  assign sh = !bh && ({1'b0, idx} < frame_used);

  always_comb begin
    state_next.brew_active = active_next;
    state_next.brew_slots = brew_cur;
    state_next.steam_slots = steam_cur;
    state_next.slot_index = (idx >= FRAME - SLOT_W'(1)) ? '0 : idx + SLOT_W'(1);
  end

  // drive outputs
  always_comb begin
    out_word.pump_on = refill;
    out_word.water_valve_open = refill;
    out_word.fill_valve_open = refill;
    if (brewing) begin
      out_word.pump_on = !flow_mode[FLOW_PUMP_OFF_BIT];
      out_word.water_valve_open = !flow_mode[FLOW_VALVE_SHUT_BIT];
    end
    out_word.brew_heater_on = bh;
    out_word.steam_heater_on = sh;
    out_word.brewing = brewing;
  end

endmodule

/* sv/boiler_power_slot_scheduler_top.sv */
// top level of the boiler power slot scheduler: handshakes, registers, config
// depends on bpss_pkg and bpss_tick
//
// Usage:
//   One input word per control tick on in_valid/in_stall carries the brew
//   switch, the tank and boiler levels and the two heater demands. For each
//   accepted word exactly one output word leaves on out_valid/out_stall with
//   the pump, valve and heater drives for that tick.
//   The word is captured in an input register, and the tick logic (a handful
//   of compares and short adds) feeds the output register, which loads
//   together with the step of the scheduler state.
//   Throughput is one word per cycle while the receiver does not stall; the
//   input register keeps filling while the output register is being taken.
//   When the receiver stalls, the output word holds; the input register
//   holds one more word and then in_stall rises until the output drains.
//   Configuration (flow_mode at index 0, eco_mode at index 1) on cfg_wr_en/
//   cfg_index/cfg_data is the user's to write only while no word is in flight.
//   Reset (rst, synchronous) empties both registers, clears the brew flag,
//   puts the frame at its first slot with no shares, and zeroes the config.
module boiler_power_slot_scheduler_top #(
  parameter int FRAME_SLOTS = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bpss_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bpss_pkg::out_word_t                out_word,
  input  logic                               cfg_wr_en,
  input  logic [bpss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bpss_pkg::*;

  localparam logic [SLOT_W-1:0] FRAME = SLOT_W'(FRAME_SLOTS);

  logic         s1_valid;
  in_word_t     s1_word;
  logic         advance;
  logic         in_take;
  logic [1:0]   flow_mode;
  logic         eco_mode;
  sched_state_t state;
  sched_state_t state_next;
  out_word_t    result_next;

  // pipeline control
  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_mode <= '0;
      eco_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FLOW_MODE: flow_mode <= cfg_data[1:0];
        CFG_ECO_MODE:  eco_mode <= cfg_data[0];
        default:       flow_mode <= flow_mode;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word <= in_word;
    end
  end

  bpss_tick #(
    .FRAME_SLOTS(FRAME_SLOTS)
  ) u_tick (
    .in_word   (s1_word),
    .state     (state),
    .flow_mode (flow_mode),
    .eco_mode  (eco_mode),
    .out_word  (result_next),
    .state_next(state_next)
  );

  // scheduler state steps once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result_next;
    end
  end

  // checks
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> s1_valid)
    else $error("accepted word not held in input register");

  a_slot_in_frame: assert property (@(posedge clk) disable iff (rst)
    state.slot_index < FRAME)
    else $error("slot index outside frame");

  a_shares_fit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, state.brew_slots} + {1'b0, state.steam_slots}) <= {1'b0, FRAME})
    else $error("heater shares overflow frame");

  a_one_heater: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.brew_heater_on && out_word.steam_heater_on))
    else $error("both heaters on in one slot");

  a_refill_not_brew: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.fill_valve_open |->
      !out_word.brewing && out_word.pump_on && out_word.water_valve_open)
    else $error("fill valve open outside refill");

endmodule
